// File: src/ucr_pkg.sv
// Shared types and constants for the uptime clock report block.
package ucr_pkg;

    localparam logic [7:0] TPS_RESET     = 8'd10;
    localparam logic [7:0] REQ_RESET     = 8'h28;
    localparam logic [7:0] HEADER_BYTE   = 8'h8E;
    localparam logic [7:0] TRAILER_BYTE  = 8'hBB;
    localparam logic [7:0] RESERVED_BYTE = 8'h00;

    localparam logic [5:0] SEC_PER_MIN  = 6'd60;
    localparam logic [5:0] MIN_PER_HOUR = 6'd60;
    localparam logic [4:0] HOUR_PER_DAY = 5'd24;

    localparam int unsigned CFG_IDX_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICKS_PER_SECOND = 8'd0,
        CFG_REQUEST_CODE     = 8'd1
    } t_cfg_idx;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_BYTE = 1'b1
    } t_opcode;

    // Byte positions within a report.
    typedef enum logic [2:0] {
        SLOT_HDR  = 3'd0,
        SLOT_SEC  = 3'd1,
        SLOT_MIN  = 3'd2,
        SLOT_HOUR = 3'd3,
        SLOT_DAYH = 3'd4,
        SLOT_DAYL = 3'd5,
        SLOT_RSV  = 3'd6,
        SLOT_TRL  = 3'd7
    } t_slot;

    typedef struct packed {
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [4:0]  hours;
        logic [15:0] day_count;
    } t_time;

endpackage

// File: src/ucr_time.sv
// Tick prescaler and time-of-day counter with day count.
module ucr_time (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_tick,
    input  logic [7:0]     i_ticks_per_second,
    output ucr_pkg::t_time o_time
);

    logic [7:0]     r_prescale;
    logic [7:0]     n_prescale;
    ucr_pkg::t_time r_time;
    ucr_pkg::t_time n_time;
    logic [7:0]     prescale_inc;
    logic [5:0]     sec_inc;
    logic [5:0]     min_inc;
    logic [4:0]     hour_inc;

    always_comb begin
        prescale_inc = r_prescale + 8'd1;
        sec_inc      = r_time.seconds + 6'd1;
        min_inc      = r_time.minutes + 6'd1;
        hour_inc     = r_time.hours + 5'd1;
        n_prescale   = r_prescale;
        n_time       = r_time;
        if (i_tick) begin
            n_prescale = prescale_inc;
            if (prescale_inc >= i_ticks_per_second) begin
                n_prescale = 8'd0;
                // carry chain: seconds -> minutes -> hours -> days
                if (sec_inc >= ucr_pkg::SEC_PER_MIN) begin
                    n_time.seconds = 6'd0;
                    if (min_inc >= ucr_pkg::MIN_PER_HOUR) begin
                        n_time.minutes = 6'd0;
                        if (hour_inc >= ucr_pkg::HOUR_PER_DAY) begin
                            n_time.hours     = 5'd0;
                            n_time.day_count = r_time.day_count + 16'd1;
                        end else begin
                            n_time.hours = hour_inc;
                        end
                    end else begin
                        n_time.minutes = min_inc;
                    end
                end else begin
                    n_time.seconds = sec_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= 8'd0;
            r_time     <= '0;
        end else begin
            r_prescale <= n_prescale;
            r_time     <= n_time;
        end
    end

    assign o_time = r_time;

endmodule

// File: src/ucr_report.sv
// Report serializer: snapshots the time and sends the eight-byte report.
module ucr_report (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ucr_pkg::t_time    i_time,
    output logic              o_ready,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_tx_byte,
    output logic              o_last
);

    logic           r_busy;
    ucr_pkg::t_slot r_slot;
    ucr_pkg::t_time r_snap;
    logic           r_pend_valid;
    ucr_pkg::t_time r_pend;
    logic           take;
    logic           done;
    logic           load_now;
    logic           load_wait;

    assign take      = r_busy && !i_out_stall;
    assign done      = take && (r_slot == ucr_pkg::SLOT_TRL);
    assign load_now  = i_load && (!r_busy || done);
    assign load_wait = i_load && r_busy && !done;
    // a second report parks in r_pend, so ready never looks at the output stall
    assign o_ready   = !r_pend_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_slot       <= ucr_pkg::SLOT_HDR;
            r_pend_valid <= 1'b0;
        end else begin
            if (done) begin
                r_busy <= r_pend_valid || i_load;
                r_slot <= ucr_pkg::SLOT_HDR;
            end else if (take) begin
                r_slot <= ucr_pkg::t_slot'(r_slot + 3'd1);
            end else if (i_load && !r_busy) begin
                r_busy <= 1'b1;
            end
            if (done) begin
                r_pend_valid <= 1'b0;
            end else if (load_wait) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_now) begin
            r_snap <= i_time;
        end else if (done && r_pend_valid) begin
            r_snap <= r_pend;
        end
        if (load_wait) begin
            r_pend <= i_time;
        end
    end

    always_comb begin
        case (r_slot)
            ucr_pkg::SLOT_HDR:  o_tx_byte = ucr_pkg::HEADER_BYTE;
            ucr_pkg::SLOT_SEC:  o_tx_byte = {2'b00, r_snap.seconds};
            ucr_pkg::SLOT_MIN:  o_tx_byte = {2'b00, r_snap.minutes};
            ucr_pkg::SLOT_HOUR: o_tx_byte = {3'b000, r_snap.hours};
            ucr_pkg::SLOT_DAYH: o_tx_byte = r_snap.day_count[15:8];
            ucr_pkg::SLOT_DAYL: o_tx_byte = r_snap.day_count[7:0];
            ucr_pkg::SLOT_RSV:  o_tx_byte = ucr_pkg::RESERVED_BYTE;
            ucr_pkg::SLOT_TRL:  o_tx_byte = ucr_pkg::TRAILER_BYTE;
            default:            o_tx_byte = ucr_pkg::RESERVED_BYTE;
        endcase
    end

    assign o_out_valid = r_busy;
    assign o_last      = (r_slot == ucr_pkg::SLOT_TRL);

endmodule

// File: src/uptime_clock_report_top.sv
// Uptime clock with day count and byte-triggered eight-byte time report.
// A request is registered and decoded; a match loads a time snapshot into the serializer.
// Throughput: one request per cycle unless stalled; reports stream back to back, one more
// waits in the serializer and a third report request stalls the input until a report ends.
// Reset (synchronous, active low) clears the time, prescaler and serializer and
// restores ticks_per_second to 10 and request_code to 0x28.
module uptime_clock_report_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_opcode,
    input  logic [7:0]                   i_rx_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [7:0]                   o_tx_byte,
    output logic                         o_last,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ucr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                   i_cfg_data
);

    logic              r_in_valid;
    logic              r_in_opcode;
    logic [7:0]        r_in_rx;
    logic [7:0]        r_tps;
    logic [7:0]        r_req;
    logic              in_accept;
    logic              is_tick;
    logic              req_hit;
    logic              proc_ok;
    logic              rpt_load;
    logic              rpt_ready;
    ucr_pkg::t_time    cur_time;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= ucr_pkg::TPS_RESET;
            r_req <= ucr_pkg::REQ_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ucr_pkg::CFG_TICKS_PER_SECOND: r_tps <= i_cfg_data;
                ucr_pkg::CFG_REQUEST_CODE:     r_req <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Registered request is decoded here; a report request waits for the serializer.
    assign is_tick    = r_in_valid && (r_in_opcode == ucr_pkg::OP_TICK);
    assign req_hit    = r_in_valid && (r_in_opcode == ucr_pkg::OP_BYTE) && (r_in_rx == r_req);
    assign proc_ok    = !req_hit || rpt_ready;
    assign rpt_load   = req_hit && rpt_ready;
    assign o_in_stall = r_in_valid && !proc_ok;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc_ok) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_opcode <= i_opcode;
            r_in_rx     <= i_rx_byte;
        end
    end

    ucr_time u_time (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_tick             (is_tick),
        .i_ticks_per_second (r_tps),
        .o_time             (cur_time)
    );

    ucr_report u_report (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (rpt_load),
        .i_time      (cur_time),
        .o_ready     (rpt_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_tx_byte   (o_tx_byte),
        .o_last      (o_last)
    );

endmodule
